/* rtl/core/bmx_pkg.sv */
// Package for the blend xorshift FNV mixer: item and state types, op codes,
// constants and the arithmetic helpers shared by the datapath and top level.
// Depends on nothing.
package bmx_pkg;

    // Fixed field widths.
    localparam int ACC_W   = 64;
    localparam int LEVEL_W = 32;
    localparam int PHASE_W = 6;
    localparam int FLAG_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int CFG_DW  = 64;
    localparam int CFG_AW  = 4;

    // Default phase modulus.
    localparam int PHASE_MODULUS_DEF = 42;

    // Mixing constants.
    localparam logic [ACC_W-1:0]   FNV_PRIME   = 64'h0000_0100_0000_01B3;
    localparam logic [LEVEL_W-1:0] LEVEL_INIT  = 32'h0000_8000;
    localparam logic [LEVEL_W-1:0] CLOSE_LIMIT = 32'h0000_0800;
    localparam int                 XS_SHL_A    = 13;
    localparam int                 XS_SHR      = 7;
    localparam int                 XS_SHL_B    = 17;
    localparam int                 PHASE_ADV_W = 5;

    // Register map.
    localparam logic [CFG_AW-1:0] ADDR_SEED = 4'h0;

    // Flag codes.
    localparam logic [FLAG_W-1:0] FLAG_NONE  = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_CLOSE = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_APART = 2'd2;

    typedef enum logic [1:0] {
        OP_STEP     = 2'd0,
        OP_COLLAPSE = 2'd1,
        OP_INJECT   = 2'd2,
        OP_RESTART  = 2'd3
    } t_op;

    // One input item as held in the input register.
    typedef struct packed {
        logic [1:0]                op;
        logic signed [LEVEL_W-1:0] coherence_in;
        logic signed [LEVEL_W-1:0] entropy_in;
        logic [BYTE_W-1:0]         data_byte;
        logic                      last;
    } t_item;

    // Full mixer state, which is also the result item.
    typedef struct packed {
        logic [ACC_W-1:0]          acc;
        logic [PHASE_W-1:0]        phase;
        logic signed [LEVEL_W-1:0] coherence;
        logic signed [LEVEL_W-1:0] entropy;
        logic [FLAG_W-1:0]         flag;
    } t_state;

    // Blend (3*cur + in) modulo 2^32, then arithmetic shift right by two.
    function automatic logic [LEVEL_W-1:0] blend_level(
        input logic [LEVEL_W-1:0] cur,
        input logic [LEVEL_W-1:0] lvl_in
    );
        logic [LEVEL_W-1:0] t;
        t = {cur[LEVEL_W-2:0], 1'b0} + cur + lvl_in;
        return {t[LEVEL_W-1], t[LEVEL_W-1], t[LEVEL_W-1:2]};
    endfunction

    // Multiply by the FNV prime (2^40 + 0x1B3) modulo 2^64 with shifts and adds.
    function automatic logic [ACC_W-1:0] fnv_mul(input logic [ACC_W-1:0] a);
        logic [ACC_W-1:0] lo;
        lo = (a << 8) + (a << 7) + (a << 5) + (a << 4) + (a << 1) + a;
        return (a << 40) + lo;
    endfunction

    // State after reset or restart.
    function automatic t_state init_state(input logic [ACC_W-1:0] seed);
        t_state s;
        s.acc       = seed ^ FNV_PRIME;
        s.phase     = '0;
        s.coherence = LEVEL_INIT;
        s.entropy   = LEVEL_INIT;
        s.flag      = FLAG_NONE;
        return s;
    endfunction

endpackage

/* rtl/core/bmx_in_if.sv */
// Input channel of the mixer: valid/ready handshake with one input item.
// Depends on bmx_pkg for field widths.
interface bmx_in_if;
    import bmx_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic signed [LEVEL_W-1:0] coherence_in;
    logic signed [LEVEL_W-1:0] entropy_in;
    logic [BYTE_W-1:0]         data_byte;
    logic                      last;

    modport source (
        output valid, op, coherence_in, entropy_in, data_byte, last,
        input  ready
    );
    modport sink (
        input  valid, op, coherence_in, entropy_in, data_byte, last,
        output ready
    );
endinterface

/* rtl/core/bmx_out_if.sv */
// Result channel of the mixer: valid/ready handshake with the full state.
// Depends on bmx_pkg for field widths.
interface bmx_out_if;
    import bmx_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ACC_W-1:0]          accumulator;
    logic [PHASE_W-1:0]        phase;
    logic signed [LEVEL_W-1:0] coherence;
    logic signed [LEVEL_W-1:0] entropy;
    logic [FLAG_W-1:0]         flag;

    modport source (
        output valid, accumulator, phase, coherence, entropy, flag,
        input  ready
    );
    modport sink (
        input  valid, accumulator, phase, coherence, entropy, flag,
        output ready
    );
endinterface

/* rtl/core/bmx_cfg.sv */
// APB-style configuration port holding the 64-bit seed register.
// Depends on bmx_pkg for the register map and widths.
module bmx_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bmx_pkg::CFG_AW-1:0]  paddr,
    input  logic [bmx_pkg::CFG_DW-1:0]  pwdata,
    output logic [bmx_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output logic [bmx_pkg::ACC_W-1:0]   o_seed
);
    import bmx_pkg::*;

    logic [ACC_W-1:0] r_seed;
    logic             wr_seed;

    // Write strobe in the access phase of a write to the seed address.
    assign pready  = 1'b1;
    assign wr_seed = psel && penable && pwrite && (paddr == ADDR_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (wr_seed) begin
            r_seed <= pwdata;
        end
    end

    // Read back the seed; other addresses read as zero.
    assign prdata = (paddr == ADDR_SEED) ? r_seed : '0;
    assign o_seed = r_seed;
endmodule

/* rtl/core/bmx_in_reg.sv */
// Input register of the mixer: captures one item and holds it until the
// result register can take its outcome. Depends on bmx_pkg and bmx_in_if.
module bmx_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bmx_in_if.sink         i_in,
    input  logic           i_advance,
    output logic           o_valid,
    output bmx_pkg::t_item o_item
);
    import bmx_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    // The register frees up in the same cycle its item moves on.
    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_advance);
        end
    end

    // Payload carries no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op           <= i_in.op;
            r_item.coherence_in <= i_in.coherence_in;
            r_item.entropy_in   <= i_in.entropy_in;
            r_item.data_byte    <= i_in.data_byte;
            r_item.last         <= i_in.last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

/* rtl/core/bmx_mix.sv */
// Next-state logic of the mixer: step, collapse, inject and restart applied
// to the current state. Depends on bmx_pkg for types, codes and helpers.
module bmx_mix #(
    parameter int PHASE_MODULUS = bmx_pkg::PHASE_MODULUS_DEF
) (
    input  bmx_pkg::t_item             i_item,
    input  bmx_pkg::t_state            i_state,
    input  logic [bmx_pkg::ACC_W-1:0]  i_seed,
    output bmx_pkg::t_state            o_state
);
    import bmx_pkg::*;

    localparam logic [PHASE_W:0]   MOD_EXT  = (PHASE_W + 1)'(PHASE_MODULUS);
    localparam logic [PHASE_W-1:0] MOD_LAST = PHASE_W'(PHASE_MODULUS - 1);

    logic [LEVEL_W-1:0] coh_blend;
    logic [LEVEL_W-1:0] ent_blend;
    logic [ACC_W-1:0]   xs_a;
    logic [ACC_W-1:0]   xs_b;
    logic [ACC_W-1:0]   xs_c;
    logic [ACC_W-1:0]   step_acc;
    logic [PHASE_W-1:0] step_phase;
    logic [LEVEL_W:0]   diff;
    logic [LEVEL_W:0]   diff_abs;
    logic [LEVEL_W-1:0] delta;
    logic [FLAG_W-1:0]  col_flag;
    logic [ACC_W-1:0]   col_acc;
    logic [ACC_W-1:0]   inj_acc;
    logic [PHASE_W:0]   inj_sum;
    logic [PHASE_W-1:0] inj_phase;

    // Step: blend both levels, bump the phase, xorshift then fold in levels.
    always_comb begin
        coh_blend  = blend_level(i_state.coherence, i_item.coherence_in);
        ent_blend  = blend_level(i_state.entropy, i_item.entropy_in);
        step_phase = (i_state.phase == MOD_LAST) ? '0 : i_state.phase + 1'b1;
        xs_a       = i_state.acc ^ (i_state.acc << XS_SHL_A);
        xs_b       = xs_a ^ (xs_a >> XS_SHR);
        xs_c       = xs_b ^ (xs_b << XS_SHL_B);
        step_acc   = (xs_c ^ {{(ACC_W-LEVEL_W){1'b0}}, coh_blend})
                   + {{(ACC_W-LEVEL_W){1'b0}}, ent_blend};
    end

    // Collapse: absolute level difference, compared against the close limit.
    always_comb begin
        diff     = {i_state.coherence[LEVEL_W-1], i_state.coherence}
                 - {i_state.entropy[LEVEL_W-1], i_state.entropy};
        diff_abs = diff[LEVEL_W] ? (~diff + 1'b1) : diff;
        delta    = diff_abs[LEVEL_W-1:0];
        col_flag = (delta <= CLOSE_LIMIT) ? FLAG_CLOSE : FLAG_APART;
        col_acc  = i_state.acc
                 ^ {{(ACC_W-LEVEL_W-16){1'b0}}, delta, 16'h0000}
                 ^ {{(ACC_W-FLAG_W){1'b0}}, col_flag};
    end

    // Inject: one FNV-1a byte; the last byte advances the phase by the new acc[4:0], modulo the phase modulus.
    always_comb begin
        inj_acc = fnv_mul(i_state.acc ^ {{(ACC_W-BYTE_W){1'b0}}, i_item.data_byte});
        inj_sum = {1'b0, i_state.phase}
                + {{(PHASE_W+1-PHASE_ADV_W){1'b0}}, inj_acc[PHASE_ADV_W-1:0]};
        if (inj_sum >= MOD_EXT) begin
            inj_sum = inj_sum - MOD_EXT;
        end
        inj_phase = i_item.last ? inj_sum[PHASE_W-1:0] : i_state.phase;
    end

    // Select the outcome of the item's op.
    always_comb begin
        o_state = i_state;
        unique case (t_op'(i_item.op))
            OP_STEP: begin
                o_state.acc       = step_acc;
                o_state.phase     = step_phase;
                o_state.coherence = coh_blend;
                o_state.entropy   = ent_blend;
            end
            OP_COLLAPSE: begin
                o_state.acc  = col_acc;
                o_state.flag = col_flag;
            end
            OP_INJECT: begin
                o_state.acc   = inj_acc;
                o_state.phase = inj_phase;
            end
            OP_RESTART: begin
                o_state = init_state(i_seed);
            end
        endcase
    end
endmodule

/* rtl/core/blend_xorshift_fnv_mixer_core.sv */
// Blend xorshift FNV mixer top level: input register, next-state logic and a
// result register that is also the mixer state.
// An accepted item passes through the input register, then into the result register.
// Throughput: one item per cycle while results are taken; the state loop closes
// through the result register alone. Reset (synchronous, active low) empties both
// registers, loads the state from a zero seed and clears the seed register.
module blend_xorshift_fnv_mixer_core #(
    parameter int PHASE_MODULUS = bmx_pkg::PHASE_MODULUS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bmx_in_if.sink                      i_in,
    bmx_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bmx_pkg::CFG_AW-1:0]  paddr,
    input  logic [bmx_pkg::CFG_DW-1:0]  pwdata,
    output logic [bmx_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);
    import bmx_pkg::*;

    logic       [ACC_W-1:0] seed;
    logic                   item_valid;
    t_item                  item;
    logic                   advance;
    t_state                 r_state;
    t_state                 n_state;
    logic                   r_out_valid;

    bmx_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_seed  (seed)
    );

    bmx_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (item_valid),
        .o_item    (item)
    );

    bmx_mix #(
        .PHASE_MODULUS (PHASE_MODULUS)
    ) u_mix (
        .i_item  (item),
        .i_state (r_state),
        .i_seed  (seed),
        .o_state (n_state)
    );

    // An item moves on when the result register is empty or being drained.
    assign advance = item_valid && (!r_out_valid || o_out.ready);

    // The result register holds the mixer state and changes only on advance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= init_state('0);
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            r_out_valid <= advance || (r_out_valid && !o_out.ready);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.accumulator = r_state.acc;
    assign o_out.phase       = r_state.phase;
    assign o_out.coherence   = r_state.coherence;
    assign o_out.entropy     = r_state.entropy;
    assign o_out.flag        = r_state.flag;
endmodule

/* sim/tb_top.sv */
// Testbench for the blend xorshift FNV mixer core: drives directed and random
// items, predicts the full mixer state per item and checks every result.
// Depends on bmx_pkg, bmx_in_if, bmx_out_if and blend_xorshift_fnv_mixer_core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bmx_pkg::*;

    localparam int MIX_PHASE_MOD = PHASE_MODULUS_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEMS_PER_SET = 150;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [CFG_AW-1:0]   paddr   = '0;
    logic [CFG_DW-1:0]   pwdata  = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    bmx_in_if  in_if();
    bmx_out_if out_if();

    blend_xorshift_fnv_mixer_core #(
        .PHASE_MODULUS(MIX_PHASE_MOD)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shared between the stimulus thread, the driver and the monitor.
    t_item       pending_items[$];
    t_state      expected_states[$];
    t_state      mixer_state;
    logic [63:0] seed_shadow;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          recv_hold_left = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;

    always #2 i_clk = ~i_clk;

    // Blend one level: (3*cur + in) modulo 2^32, arithmetic shift right by two.
    function automatic logic signed [31:0] blend(input logic [31:0] cur,
                                                 input logic [31:0] lvl);
        logic [31:0] sum;
        sum = cur * 32'd3 + lvl;
        return $signed(sum) >>> 2;
    endfunction

    // Next mixer state for one item.
    function automatic t_state mix_predict(input t_state s, input t_item it);
        logic signed [63:0] c_ext;
        logic signed [63:0] h_ext;
        logic signed [63:0] diff;
        logic [31:0]        delta;
        int                 ph;
        case (t_op'(it.op))
            OP_STEP: begin
                s.coherence = blend(s.coherence, it.coherence_in);
                s.entropy   = blend(s.entropy, it.entropy_in);
                s.phase     = (int'(s.phase) == MIX_PHASE_MOD - 1) ? '0 : s.phase + 1'b1;
                s.acc       = s.acc ^ (s.acc << XS_SHL_A);
                s.acc       = s.acc ^ (s.acc >> XS_SHR);
                s.acc       = s.acc ^ (s.acc << XS_SHL_B);
                s.acc       = s.acc ^ {32'd0, s.coherence};
                s.acc       = s.acc + {32'd0, s.entropy};
            end
            OP_COLLAPSE: begin
                c_ext  = s.coherence;
                h_ext  = s.entropy;
                diff   = (c_ext >= h_ext) ? c_ext - h_ext : h_ext - c_ext;
                delta  = diff[31:0];
                s.flag = (delta <= CLOSE_LIMIT) ? FLAG_CLOSE : FLAG_APART;
                s.acc  = s.acc ^ ({32'd0, delta} << 16) ^ {62'd0, s.flag};
            end
            OP_INJECT: begin
                s.acc = (s.acc ^ {56'd0, it.data_byte}) * FNV_PRIME;
                if (it.last) begin
                    ph      = (int'(s.phase) + int'(s.acc[4:0])) % MIX_PHASE_MOD;
                    s.phase = PHASE_W'(ph);
                end
            end
            default: begin
                s.acc       = seed_shadow ^ FNV_PRIME;
                s.phase     = '0;
                s.coherence = LEVEL_INIT;
                s.entropy   = LEVEL_INIT;
                s.flag      = FLAG_NONE;
            end
        endcase
        return s;
    endfunction

    // Driver: predict each accepted item, then offer the next pending one.
    always @(posedge i_clk) begin : drive_items
        t_item nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                nxt.op           = in_if.op;
                nxt.coherence_in = in_if.coherence_in;
                nxt.entropy_in   = in_if.entropy_in;
                nxt.data_byte    = in_if.data_byte;
                nxt.last         = in_if.last;
                mixer_state      = mix_predict(mixer_state, nxt);
                expected_states.push_back(mixer_state);
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt                 = pending_items.pop_front();
                    in_if.op           <= nxt.op;
                    in_if.coherence_in <= nxt.coherence_in;
                    in_if.entropy_in   <= nxt.entropy_in;
                    in_if.data_byte    <= nxt.data_byte;
                    in_if.last         <= nxt.last;
                    in_if.valid        <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
        if (got_v !== exp_v) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, got_v);
        end
    endtask

    // Monitor: check each accepted result, then decide on backpressure.
    always @(posedge i_clk) begin : check_results
        t_state want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_states.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, got acc %h",
                         $time, out_if.accumulator);
            end else begin
                want = expected_states.pop_front();
                compare_field("accumulator", want.acc, out_if.accumulator);
                compare_field("phase", want.phase, out_if.phase);
                compare_field("coherence", want.coherence, out_if.coherence);
                compare_field("entropy", want.entropy, out_if.entropy);
                compare_field("flag", want.flag, out_if.flag);
            end
        end
        if (recv_hold_left > 0) begin
            recv_hold_left <= recv_hold_left - 1;
            out_if.ready   <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_item(input t_op op, input logic [31:0] c_in,
                             input logic [31:0] h_in, input logic [7:0] b,
                             input logic lst);
        t_item it;
        it.op           = op;
        it.coherence_in = c_in;
        it.entropy_in   = h_in;
        it.data_byte    = b;
        it.last         = lst;
        pending_items.push_back(it);
    endtask

    // Step input that moves a level from cur exactly to target, for a target whose top three bits agree.
    function automatic logic [31:0] level_for(input logic [31:0] cur,
                                              input logic [31:0] target);
        return (target << 2) - cur * 32'd3;
    endfunction

    function automatic logic [31:0] rand_level();
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1: return 32'h8000 + $urandom_range(0, 32'h4000) - 32'h2000;
            default: return $urandom;
        endcase
    endfunction

    // Random mix of steps, collapses, well-formed inject runs and restarts.
    task automatic queue_random(input int count);
        int          n;
        int          sel;
        int          run_len;
        logic [31:0] c_in;
        n = 0;
        while (n < count) begin
            sel = $urandom_range(99);
            if (sel < 35) begin
                c_in = rand_level();
                if ($urandom_range(1) == 0)
                    push_item(OP_STEP, c_in, c_in + $urandom_range(0, 4096) - 32'h800,
                              8'($urandom), 1'($urandom));
                else
                    push_item(OP_STEP, c_in, rand_level(), 8'($urandom), 1'($urandom));
                n++;
            end else if (sel < 55) begin
                push_item(OP_COLLAPSE, $urandom, $urandom, 8'($urandom), 1'($urandom));
                n++;
            end else if (sel < 93) begin
                run_len = $urandom_range(1, 6);
                for (int k = 0; k < run_len; k++)
                    push_item(OP_INJECT, $urandom, $urandom, 8'($urandom),
                              k == run_len - 1);
                n += run_len;
            end else begin
                push_item(OP_RESTART, $urandom, $urandom, 8'($urandom), 1'($urandom));
                n++;
            end
        end
    endtask

    // Register write through the configuration port: a setup phase, then an access phase.
    task automatic write_seed(input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SEED;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        seed_shadow  = value;
    endtask

    // Block idle: nothing queued, nothing offered, every result back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || in_if.valid || expected_states.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : run_test
        logic [63:0] seeds[4];
        int          idle_set[4];
        int          stall_set[4];
        logic [31:0] c_cur;
        logic [31:0] h_cur;
        seeds     = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom},
                      64'h8000_0000_0000_0001};
        idle_set  = '{0, 70, 0, 8};
        stall_set = '{0, 0, 70, 8};

        in_if.valid        = 1'b0;
        in_if.op           = OP_STEP;
        in_if.coherence_in = '0;
        in_if.entropy_in   = '0;
        in_if.data_byte    = '0;
        in_if.last         = 1'b0;
        out_if.ready       = 1'b0;

        // Predictor starts from the reset state with a zero seed.
        seed_shadow           = '0;
        mixer_state.acc       = FNV_PRIME;
        mixer_state.phase     = '0;
        mixer_state.coherence = LEVEL_INIT;
        mixer_state.entropy   = LEVEL_INIT;
        mixer_state.flag      = FLAG_NONE;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: collapse from reset, collapse boundaries, blend overflow,
        // inject runs and ignored fields.
        push_item(OP_COLLAPSE, 32'h0, 32'h0, 8'h0, 1'b0);
        push_item(OP_RESTART, 32'h0, 32'h0, 8'h0, 1'b0);
        c_cur = LEVEL_INIT;
        h_cur = LEVEL_INIT;
        push_item(OP_STEP, level_for(c_cur, 32'h1_0000), level_for(h_cur, 32'h1_0800),
                  8'h0, 1'b0);
        push_item(OP_COLLAPSE, 32'h0, 32'h0, 8'h0, 1'b0);
        push_item(OP_STEP, 32'h1_0000, level_for(32'h1_0800, 32'h1_0801), 8'h0, 1'b0);
        push_item(OP_COLLAPSE, 32'h0, 32'h0, 8'h0, 1'b0);
        push_item(OP_STEP, 32'h1_0000, level_for(32'h1_0801, 32'h1_0000), 8'h0, 1'b0);
        push_item(OP_COLLAPSE, 32'h0, 32'h0, 8'h0, 1'b0);
        push_item(OP_STEP, level_for(32'h1_0000, 32'h1FFF_FFFF),
                  level_for(32'h1_0000, 32'hE000_0000), 8'h0, 1'b0);
        push_item(OP_COLLAPSE, 32'h0, 32'h0, 8'h0, 1'b0);
        push_item(OP_STEP, level_for(32'h1FFF_FFFF, 32'hE000_0000),
                  level_for(32'hE000_0000, 32'h1FFF_FFFF), 8'h0, 1'b0);
        push_item(OP_COLLAPSE, 32'h0, 32'h0, 8'h0, 1'b0);
        push_item(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 8'h0, 1'b0);
        push_item(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 8'h0, 1'b0);
        push_item(OP_STEP, 32'hFFFF_FFFF, 32'h0, 8'h0, 1'b0);
        push_item(OP_INJECT, 32'h0, 32'h0, 8'h00, 1'b0);
        push_item(OP_INJECT, 32'h0, 32'h0, 8'hFF, 1'b0);
        push_item(OP_INJECT, 32'h0, 32'h0, 8'hA5, 1'b1);
        push_item(OP_INJECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h5A, 1'b1);
        push_item(OP_STEP, 32'h0, 32'h0, 8'hFF, 1'b1);
        push_item(OP_COLLAPSE, 32'hDEAD_BEEF, 32'h1234_5678, 8'hFF, 1'b1);
        push_item(OP_RESTART, 32'hFFFF_FFFF, 32'h8000_0000, 8'hFF, 1'b1);
        push_item(OP_INJECT, 32'h0, 32'h0, 8'h7F, 1'b1);
        wait_drained();

        // Random part: one seed and one idling and stalling pattern per set.
        for (int p = 0; p < 4; p++) begin
            write_seed(seeds[p]);
            @(negedge i_clk);
            send_idle_pct  = idle_set[p];
            recv_stall_pct = stall_set[p];
            push_item(OP_RESTART, $urandom, $urandom, 8'($urandom), 1'($urandom));
            queue_random(ITEMS_PER_SET / 2);
            // Receiver holds off while the sender keeps offering, filling the block.
            if (p == 0)
                recv_hold_left = 200;
            // Sender pauses mid-set until every result is back.
            wait_drained();
            queue_random(ITEMS_PER_SET / 2);
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* blend_xorshift_fnv_mixer_core.f */
rtl/core/bmx_pkg.sv
rtl/core/bmx_in_if.sv
rtl/core/bmx_out_if.sv
rtl/core/bmx_cfg.sv
rtl/core/bmx_in_reg.sv
rtl/core/bmx_mix.sv
rtl/core/blend_xorshift_fnv_mixer_core.sv
sim/tb_top.sv
